// ===== hw/rtl/free_running_compare_timer_unit_assert.svh =====
// Assertion macros for the free-running compare timer unit.
`ifndef FREE_RUNNING_COMPARE_TIMER_UNIT_ASSERT_SVH
`define FREE_RUNNING_COMPARE_TIMER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define FRCT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("frct assertion failed (same cycle)");

// Next-cycle implication, disabled while in reset.
`define FRCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("frct assertion failed (next cycle)");

`endif

// ===== hw/rtl/frct_pkg.sv =====
// Package: word types and register/opcode codes for the compare timer.
`default_nettype none

package frct_pkg;

    localparam int OPCODE_W = 2;
    localparam int REG_IDX_W = 3;
    localparam int DATA_W = 32;
    localparam int CNT_W = 64;
    localparam int IRQ_W = 4;

    localparam logic [OPCODE_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_READ  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_WRITE = 2'd2;

    localparam logic [REG_IDX_W-1:0] REG_CTRL     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_CNT_LO   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_CNT_HI   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_CMP_BASE = 3'd3;

    typedef struct packed {
        logic [OPCODE_W-1:0]  opcode;
        logic [REG_IDX_W-1:0] reg_index;
        logic [DATA_W-1:0]    write_data;
    } t_in_word;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic [IRQ_W-1:0]  match_irq;
    } t_out_word;

endpackage

`default_nettype wire

// ===== hw/rtl/frct_if.sv =====
// Valid/ready channel interfaces for command and response words.
`default_nettype none

interface frct_in_if;
    import frct_pkg::*;
    logic     valid;
    logic     ready;
    t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface frct_out_if;
    import frct_pkg::*;
    logic      valid;
    logic      ready;
    t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/frct_core.sv =====
// Timer state (counter, compares, status) and single-pass word execution.
`default_nettype none

module frct_core #(
    parameter int NUM_COMPARES = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  frct_pkg::t_in_word   i_word,
    output frct_pkg::t_out_word  o_word
);
    import frct_pkg::*;

    logic [CNT_W-1:0]        r_counter;
    logic [CNT_W-1:0]        n_counter;
    logic [CNT_W-1:0]        w_counter_inc;
    logic [DATA_W-1:0]       r_cmp [NUM_COMPARES];
    logic [DATA_W-1:0]       n_cmp [NUM_COMPARES];
    logic [NUM_COMPARES-1:0] r_status;
    logic [NUM_COMPARES-1:0] n_status;
    logic [DATA_W-1:0]       w_rdata;
    logic [DATA_W-1:0]       w_status_ext;
    logic [REG_IDX_W-1:0]    w_cmp_off;
    logic                    w_cmp_range;

    assign w_counter_inc = r_counter + CNT_W'(1);
    assign w_cmp_off     = i_word.reg_index - REG_CMP_BASE;
    assign w_cmp_range   = (i_word.reg_index >= REG_CMP_BASE);

    always_comb begin
        n_counter = r_counter;
        n_status  = r_status;
        n_cmp     = r_cmp;
        w_rdata   = '0;
        case (i_word.opcode)
            OP_TICK: begin
                n_counter = w_counter_inc;
                for (int i = 0; i < NUM_COMPARES; i++) begin
                    if (r_cmp[i] == w_counter_inc[DATA_W-1:0]) begin
                        n_status[i] = 1'b1;
                    end
                end
            end
            OP_READ: begin
                case (i_word.reg_index)
                    REG_CTRL:   w_rdata = DATA_W'(r_status);
                    REG_CNT_LO: w_rdata = r_counter[DATA_W-1:0];
                    REG_CNT_HI: w_rdata = r_counter[CNT_W-1:DATA_W];
                    default: begin
                        for (int i = 0; i < NUM_COMPARES; i++) begin
                            if (w_cmp_range && int'(w_cmp_off) == i) begin
                                w_rdata = r_cmp[i];
                            end
                        end
                    end
                endcase
            end
            OP_WRITE: begin
                if (i_word.reg_index == REG_CTRL) begin
                    n_status = r_status & ~i_word.write_data[NUM_COMPARES-1:0];
                end else begin
                    for (int i = 0; i < NUM_COMPARES; i++) begin
                        if (w_cmp_range && int'(w_cmp_off) == i) begin
                            n_cmp[i] = i_word.write_data;
                        end
                    end
                end
            end
            default: begin
                n_counter = r_counter;
            end
        endcase
    end

    assign w_status_ext     = DATA_W'(n_status);
    assign o_word.read_data = w_rdata;
    assign o_word.match_irq = w_status_ext[IRQ_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter <= '0;
            r_status  <= '0;
            for (int i = 0; i < NUM_COMPARES; i++) begin
                r_cmp[i] <= '0;
            end
        end else if (i_en) begin
            r_counter <= n_counter;
            r_status  <= n_status;
            r_cmp     <= n_cmp;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/free_running_compare_timer_unit.sv =====
// Top level: command register, timer core and response register.
//
//   channel   dir   word         contents
//   i_cmd     in    t_in_word    opcode, reg_index, write_data
//   o_rsp     out   t_out_word   read_data, match_irq
//
// One command word per cycle while o_rsp does not stall; each yields exactly one response word.
// A command passes through the command register, then the core logic into the response register.
// The 64-bit increment plus the 32-bit compare per compare register sets the cycle.
// i_rst_n (synchronous) clears counter, compares, status and both valid flags.
// While o_rsp stalls, one more command is held in the command register.
`default_nettype none
`include "free_running_compare_timer_unit_assert.svh"

module free_running_compare_timer_unit #(
    parameter int NUM_COMPARES = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    frct_in_if.sink     i_cmd,
    frct_out_if.source  o_rsp
);
    import frct_pkg::*;

    logic      r_in_valid;
    t_in_word  r_in;
    logic      r_out_valid;
    t_out_word r_out;
    t_out_word w_core_word;
    logic      w_adv;
    logic      w_take;

    assign w_adv  = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign w_take = i_cmd.valid && i_cmd.ready;

    assign i_cmd.ready = !r_in_valid || w_adv;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    frct_core #(
        .NUM_COMPARES (NUM_COMPARES)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_word  (r_in),
        .o_word  (w_core_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in <= i_cmd.data;
        end
        if (w_adv) begin
            r_out <= w_core_word;
        end
    end

    `FRCT_ASSERT_NEXT(a_adv_fills_out, i_clk, i_rst_n, w_adv, r_out_valid)
    `FRCT_ASSERT_NEXT(a_cmd_not_lost, i_clk, i_rst_n, r_in_valid && !w_adv, r_in_valid)
    `FRCT_ASSERT_NEXT(a_rdata_zero_nonread, i_clk, i_rst_n, w_adv && (r_in.opcode != OP_READ), r_out.read_data == '0)
    `FRCT_ASSERT_NEXT(a_ctrl_clear_all, i_clk, i_rst_n, w_adv && (r_in.opcode == OP_WRITE) && (r_in.reg_index == REG_CTRL) && (&r_in.write_data), r_out.match_irq == '0)

endmodule

`default_nettype wire

// ===== bench/free_running_compare_timer_unit_test.sv =====
// Self-checking bench for the compare timer: directed and random command words, shadow model.
module free_running_compare_timer_unit_test;
    import frct_pkg::*;

    localparam int NUM_CMP = 4;
    localparam int CYCLE_LIMIT = 200000;
    localparam int WORDS_PER_MIX = 138;
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;

    class timer_shadow;
        logic [CNT_W-1:0]  ticks;
        logic [DATA_W-1:0] cmp_regs [NUM_CMP];
        logic [IRQ_W-1:0]  status;
        t_out_word         pending_rsp [$];
        int                mismatches;
        int                checked;
        int                irq_seen;

        function new();
            ticks = '0;
            status = '0;
            foreach (cmp_regs[k]) cmp_regs[k] = '0;
            mismatches = 0;
            checked = 0;
            irq_seen = 0;
        endfunction

        function int outstanding();
            return pending_rsp.size();
        endfunction

        function logic [DATA_W-1:0] read_reg(logic [REG_IDX_W-1:0] idx);
            int slot;
            slot = int'(idx) - int'(REG_CMP_BASE);
            if (idx == REG_CTRL) return DATA_W'(status);
            if (idx == REG_CNT_LO) return ticks[31:0];
            if (idx == REG_CNT_HI) return ticks[63:32];
            if (slot >= 0 && slot < NUM_CMP) return cmp_regs[slot];
            return '0;
        endfunction

        function void note_command(t_in_word w);
            t_out_word rsp;
            int slot;
            rsp.read_data = '0;
            slot = int'(w.reg_index) - int'(REG_CMP_BASE);
            case (w.opcode)
                OP_TICK: begin
                    ticks = ticks + CNT_W'(1);
                    for (int k = 0; k < NUM_CMP; k++) begin
                        if (cmp_regs[k] == ticks[31:0]) status[k] = 1'b1;
                    end
                end
                OP_READ: rsp.read_data = read_reg(w.reg_index);
                OP_WRITE: begin
                    if (w.reg_index == REG_CTRL) begin
                        status = status & ~w.write_data[IRQ_W-1:0];
                    end else if (slot >= 0 && slot < NUM_CMP) begin
                        cmp_regs[slot] = w.write_data;
                    end
                end
                default: ;
            endcase
            rsp.match_irq = status;
            pending_rsp.push_back(rsp);
        endfunction

        task report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
            mismatches++;
            $display("MISMATCH %s: got %h, expected %h (response %0d)", what, got, want, checked);
        endtask

        task check_response(t_out_word got);
            t_out_word want;
            if (pending_rsp.size() == 0) begin
                report_mismatch("unexpected response word", DATA_W'(got), '0);
            end else begin
                want = pending_rsp.pop_front();
                if (got.read_data !== want.read_data)
                    report_mismatch("read_data", got.read_data, want.read_data);
                if (got.match_irq !== want.match_irq)
                    report_mismatch("match_irq", DATA_W'(got.match_irq), DATA_W'(want.match_irq));
                if (want.match_irq != '0) irq_seen++;
            end
            checked++;
        endtask
    endclass

    logic clk;
    logic rst_n;
    int   src_idle_pct;
    int   sink_stall_pct;
    int   cycles;
    int   sent;

    frct_in_if  cmd_if ();
    frct_out_if rsp_if ();

    timer_shadow board = new();

    free_running_compare_timer_unit dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_if),
        .o_rsp   (rsp_if)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (cmd_if.valid && cmd_if.ready) board.note_command(cmd_if.data);
            if (rsp_if.valid && rsp_if.ready) board.check_response(rsp_if.data);
        end
        rsp_if.ready <= ($urandom_range(99) >= sink_stall_pct);
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("free_running_compare_timer_unit_test NOT OK");
            $finish;
        end
    end

    task automatic send_cmd(input t_in_word w);
        while ($urandom_range(99) < src_idle_pct) begin
            cmd_if.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.data  <= w;
        @(posedge clk);
        while (!cmd_if.ready) @(posedge clk);
        sent++;
    endtask

    task automatic issue(input logic [OPCODE_W-1:0] op, input logic [REG_IDX_W-1:0] idx,
                         input logic [DATA_W-1:0] data);
        t_in_word w;
        w.opcode = op;
        w.reg_index = idx;
        w.write_data = data;
        send_cmd(w);
    endtask

    task automatic drain();
        while (board.outstanding() != 0) @(posedge clk);
    endtask

    function automatic t_in_word random_cmd();
        t_in_word w;
        int pick;
        pick = $urandom_range(99);
        w.opcode = OP_TICK;
        w.reg_index = REG_IDX_W'($urandom_range(7));
        w.write_data = $urandom;
        if (pick >= 45 && pick < 65) begin
            w.opcode = OP_READ;
        end else if (pick >= 65 && pick < 77) begin
            // land compares a few ticks ahead so matches actually fire
            w.opcode = OP_WRITE;
            w.reg_index = REG_CMP_BASE + REG_IDX_W'($urandom_range(NUM_CMP - 1));
            if ($urandom_range(7) != 0)
                w.write_data = board.ticks[31:0] + DATA_W'($urandom_range(1, 12));
        end else if (pick >= 77 && pick < 86) begin
            w.opcode = OP_WRITE;
            w.reg_index = REG_CTRL;
            if ($urandom_range(3) != 0) w.write_data = DATA_W'($urandom_range(15));
        end else if (pick >= 86 && pick < 94) begin
            w.opcode = OP_WRITE;
        end else if (pick >= 94) begin
            w.opcode = OP_UNUSED;
        end
        return w;
    endfunction

    initial begin
        int src_mix  [4];
        int sink_mix [4];
        src_mix  = '{0, 45, 0, 24};
        sink_mix = '{0, 0, 45, 24};
        sent = 0;
        src_idle_pct = 0;
        sink_stall_pct = 0;
        rst_n <= 1'b0;
        cmd_if.valid <= 1'b0;
        cmd_if.data <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset values, double match, re-match on a set bit, ignored writes
        issue(OP_READ, REG_CTRL, '0);
        issue(OP_READ, REG_CNT_LO, '0);
        issue(OP_READ, REG_CNT_HI, '0);
        issue(OP_WRITE, REG_CMP_BASE, 32'd2);
        issue(OP_WRITE, REG_CMP_BASE + 3'd1, 32'd3);
        issue(OP_WRITE, REG_CMP_BASE + 3'd2, 32'hFFFF_FFFF);
        issue(OP_WRITE, REG_CMP_BASE + 3'd3, 32'd3);
        issue(OP_TICK, REG_CTRL, '0);
        issue(OP_TICK, REG_CTRL, '0);
        issue(OP_TICK, REG_UNUSED, 32'hFFFF_FFFF);
        issue(OP_READ, REG_CTRL, '0);
        issue(OP_READ, REG_CMP_BASE + 3'd2, 32'hFFFF_FFFF);
        issue(OP_WRITE, REG_CNT_LO, 32'hFFFF_FFFF);
        issue(OP_WRITE, REG_CNT_HI, 32'hFFFF_FFFF);
        issue(OP_READ, REG_CNT_LO, '0);
        issue(OP_WRITE, REG_CMP_BASE, 32'd4);
        issue(OP_TICK, REG_CTRL, '0);
        issue(OP_WRITE, REG_CTRL, 32'h0000_0001);
        issue(OP_UNUSED, REG_UNUSED, 32'hFFFF_FFFF);
        issue(OP_READ, REG_UNUSED, '0);
        issue(OP_WRITE, REG_UNUSED, 32'hFFFF_FFFF);
        issue(OP_WRITE, REG_CTRL, '0);
        issue(OP_READ, REG_CTRL, '0);
        issue(OP_WRITE, REG_CTRL, 32'hFFFF_FFFF);
        issue(OP_READ, REG_CMP_BASE + 3'd3, '0);

        for (int m = 0; m < 4; m++) begin
            cmd_if.valid <= 1'b0;
            @(posedge clk);
            drain();
            src_idle_pct = src_mix[m];
            sink_stall_pct = sink_mix[m];
            for (int n = 0; n < WORDS_PER_MIX; n++) send_cmd(random_cmd());
        end
        cmd_if.valid <= 1'b0;
        @(posedge clk);

        drain();
        repeat (8) @(posedge clk);
        if (board.outstanding() != 0)
            board.report_mismatch("responses never arrived", DATA_W'(board.outstanding()), '0);
        $display("sent %0d command words over four idle/stall mixes; %0d responses checked,",
                 sent, board.checked);
        $display("%0d of them with an interrupt line up, final tick count %0d",
                 board.irq_seen, board.ticks);
        if (board.mismatches == 0) begin
            $display("free_running_compare_timer_unit_test OK");
        end else begin
            $display("free_running_compare_timer_unit_test NOT OK");
        end
        $finish;
    end

endmodule
